// File: src/ptlc_pkg.sv
package ptlc_pkg;

  typedef enum logic [1:0] {
    PH_YELLOW  = 2'd0,
    PH_ALL_RED = 2'd1,
    PH_WALK    = 2'd2,
    PH_GREEN   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    WP_COUNT = 2'd0,
    WP_BLINK = 2'd1,
    WP_CLEAR = 2'd2
  } walk_part_t;

  typedef enum logic [2:0] {
    REG_YELLOW     = 3'd0,
    REG_ALL_RED    = 3'd1,
    REG_WALK_START = 3'd2,
    REG_SECOND     = 3'd3,
    REG_BLINK      = 3'd4,
    REG_CLEAR      = 3'd5,
    REG_GREEN      = 3'd6,
    REG_LOCKOUT    = 3'd7
  } cfg_reg_t;

  // lamp vector bit positions
  localparam int unsigned LB_CAR_RED    = 0;
  localparam int unsigned LB_CAR_YELLOW = 1;
  localparam int unsigned LB_CAR_GREEN  = 2;
  localparam int unsigned LB_WALK_GREEN = 3;
  localparam int unsigned LB_WALK_RED   = 4;
  localparam int unsigned LB_LIT        = 5;

  localparam logic [5:0] LAMP_YELLOW = 6'b010010;
  localparam logic [5:0] LAMP_ALLRED = 6'b010001;
  localparam logic [5:0] LAMP_WALK   = 6'b101001;
  localparam logic [5:0] LAMP_GREEN  = 6'b010100;
  localparam logic [5:0] BLINK_MASK  = 6'b110000;

  localparam logic [2:0] TOGGLES   = 3'd6;
  localparam logic [6:0] COUNT_MAX = 7'd99;

  localparam logic [15:0] YELLOW_RST  = 16'd60;
  localparam logic [15:0] ALL_RED_RST = 16'd40;
  localparam logic [6:0]  WALK_RST    = 7'd20;
  localparam logic [7:0]  SECOND_RST  = 8'd20;
  localparam logic [7:0]  BLINK_RST   = 8'd10;
  localparam logic [7:0]  CLEAR_RST   = 8'd8;
  localparam logic [15:0] GREEN_RST   = 16'd100;
  localparam logic [15:0] LOCKOUT_RST = 16'd800;

  typedef struct packed {
    phase_t      phase;
    walk_part_t  part;
    logic [15:0] tick_cnt;
    logic [6:0]  count;
    logic [2:0]  toggles;
    logic [15:0] since;
    logic        adv;
    logic [5:0]  lamp;
  } ctl_state_t;

  // tens of a value below 100: v*205 >> 11
  function automatic logic [3:0] bcd_tens(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'({8'd0, v} * 15'd205);
    return prod[14:11];
  endfunction

  function automatic logic [3:0] bcd_ones(input logic [6:0] v);
    logic [6:0] tens10;
    tens10 = 7'({3'd0, bcd_tens(v)} * 7'd10);
    return 4'(v - tens10);
  endfunction

endpackage

// File: src/pedestrian_traffic_light_controller_core.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_press, in_tick
// out_     output     out_valid/out_stall car/walk lamps, digits, display_lit, phase_now
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request per cycle when not stalled: press and tick are folded into the phase
// state in a single combinational pass and the result lands in the output register.
// in_stall follows out_stall only while a result is held, so input and output
// move together at one item per clock while not stalled. cfg_ready is always high.
// rst_n (synchronous) restores register defaults and the car yellow phase.
module pedestrian_traffic_light_controller_core
  import ptlc_pkg::*;
#(
  parameter logic [2:0] BLINK_TOGGLES = TOGGLES
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_press,
  input  logic        in_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_car_red,
  output logic        out_car_yellow,
  output logic        out_car_green,
  output logic        out_walk_green,
  output logic        out_walk_red,
  output logic [3:0]  out_tens_digit,
  output logic [3:0]  out_ones_digit,
  output logic        out_display_lit,
  output logic [1:0]  out_phase_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] yellow_r, all_red_r, green_r, lockout_r;
  logic [6:0]  walk_start_r;
  logic [7:0]  second_r, blink_r, clear_r;

  ctl_state_t st_r, st_nxt;
  logic       out_valid_r;
  logic [5:0] lamp_out_r;
  logic [3:0] tens_r, ones_r;
  phase_t     phase_out_r;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yellow_r     <= YELLOW_RST;
      all_red_r    <= ALL_RED_RST;
      walk_start_r <= WALK_RST;
      second_r     <= SECOND_RST;
      blink_r      <= BLINK_RST;
      clear_r      <= CLEAR_RST;
      green_r      <= GREEN_RST;
      lockout_r    <= LOCKOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_YELLOW:     yellow_r     <= cfg_data;
        REG_ALL_RED:    all_red_r    <= cfg_data;
        REG_WALK_START: walk_start_r <= cfg_data[6:0];
        REG_SECOND:     second_r     <= cfg_data[7:0];
        REG_BLINK:      blink_r      <= cfg_data[7:0];
        REG_CLEAR:      clear_r      <= cfg_data[7:0];
        REG_GREEN:      green_r      <= cfg_data;
        REG_LOCKOUT:    lockout_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  function automatic ctl_state_t enter_phase(input ctl_state_t s, input phase_t p,
                                             input logic [6:0] start);
    ctl_state_t r;
    r          = s;
    r.phase    = p;
    r.tick_cnt = '0;
    r.adv      = 1'b0;
    r.part     = WP_COUNT;
    r.toggles  = '0;
    unique case (p)
      PH_YELLOW:  r.lamp = LAMP_YELLOW;
      PH_ALL_RED: r.lamp = LAMP_ALLRED;
      PH_WALK: begin
        r.lamp  = LAMP_WALK;
        r.count = (start > COUNT_MAX) ? COUNT_MAX : start;
      end
      default:    r.lamp = LAMP_GREEN;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] phase_len(input ctl_state_t s);
    logic [15:0] len;
    unique case (s.phase)
      PH_YELLOW:  len = yellow_r;
      PH_ALL_RED: len = all_red_r;
      PH_GREEN:   len = green_r;
      default: begin
        if (s.part == WP_COUNT)      len = {8'd0, second_r};
        else if (s.part == WP_BLINK) len = {8'd0, blink_r};
        else                         len = {8'd0, clear_r};
      end
    endcase
    return len;
  endfunction

  always_comb begin
    st_nxt = st_r;

    // button press is handled before the tick
    if (in_press && st_nxt.since >= lockout_r) begin
      st_nxt.since = '0;
      if (st_nxt.phase != PH_WALK)
        st_nxt = enter_phase(st_nxt, phase_t'(st_nxt.phase + 2'd1), walk_start_r);
      else if (st_nxt.part != WP_COUNT && st_nxt.part != WP_BLINK)
        st_nxt = enter_phase(st_nxt, PH_GREEN, walk_start_r);
      else
        st_nxt.adv = 1'b1;
    end

    if (in_tick) begin
      if (st_nxt.since != 16'hFFFF)
        st_nxt.since = st_nxt.since + 16'd1;
      st_nxt.tick_cnt = st_nxt.tick_cnt + 16'd1;
      if (st_nxt.tick_cnt >= phase_len(st_nxt)) begin
        st_nxt.tick_cnt = '0;
        if (st_nxt.phase != PH_WALK) begin
          st_nxt = enter_phase(st_nxt, phase_t'(st_nxt.phase + 2'd1), walk_start_r);
        end else if (st_nxt.part == WP_COUNT) begin
          if (st_nxt.count != '0) begin
            st_nxt.count = st_nxt.count - 7'd1;
          end else if (st_nxt.adv) begin
            st_nxt = enter_phase(st_nxt, PH_GREEN, walk_start_r);
          end else begin
            // walk green off, red forced on, then the first toggle right away
            st_nxt.part    = WP_BLINK;
            st_nxt.lamp[LB_WALK_GREEN] = 1'b0;
            st_nxt.lamp[LB_WALK_RED]   = 1'b1;
            st_nxt.lamp    = st_nxt.lamp ^ BLINK_MASK;
            st_nxt.toggles = 3'd1;
          end
        end else if (st_nxt.part == WP_BLINK) begin
          if (st_nxt.toggles < BLINK_TOGGLES) begin
            st_nxt.lamp    = st_nxt.lamp ^ BLINK_MASK;
            st_nxt.toggles = st_nxt.toggles + 3'd1;
          end else begin
            st_nxt.lamp[LB_WALK_RED] = 1'b1;
            if (st_nxt.adv)
              st_nxt = enter_phase(st_nxt, PH_GREEN, walk_start_r);
            else
              st_nxt.part = WP_CLEAR;
          end
        end else begin
          st_nxt = enter_phase(st_nxt, PH_GREEN, walk_start_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_YELLOW;
      st_r.part     <= WP_COUNT;
      st_r.tick_cnt <= '0;
      st_r.count    <= '0;
      st_r.toggles  <= '0;
      st_r.since    <= 16'hFFFF;
      st_r.adv      <= 1'b0;
      st_r.lamp     <= LAMP_YELLOW;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lamp_out_r  <= st_nxt.lamp;
      tens_r      <= bcd_tens(st_nxt.count);
      ones_r      <= bcd_ones(st_nxt.count);
      phase_out_r <= st_nxt.phase;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_car_red     = lamp_out_r[LB_CAR_RED];
  assign out_car_yellow  = lamp_out_r[LB_CAR_YELLOW];
  assign out_car_green   = lamp_out_r[LB_CAR_GREEN];
  assign out_walk_green  = lamp_out_r[LB_WALK_GREEN];
  assign out_walk_red    = lamp_out_r[LB_WALK_RED];
  assign out_display_lit = lamp_out_r[LB_LIT];
  assign out_tens_digit  = tens_r;
  assign out_ones_digit  = ones_r;
  assign out_phase_now   = phase_out_r;

endmodule
